@@ rtl/cfa_pkg.sv @@
// shared types and constants of the contiguous fit allocator
package cfa_pkg;

   localparam int MAX_UNITS = 1024;
   localparam int ADDR_W    = 10;
   localparam int CNT_W     = 11;
   localparam int LIFE_W    = 8;
   localparam int OUT_W     = 10;
   localparam int CSR_W     = 11;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_UNITS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STRATEGY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH   = 2'd2;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_TICK  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STRAT_BEST  = 2'd0,
      STRAT_FIRST = 2'd1,
      STRAT_NEXT  = 2'd2,
      STRAT_NONE  = 2'd3
   } strat_type;

   typedef enum logic [2:0] {
      MODE_SEARCH,
      MODE_FRAG,
      MODE_WRITE,
      MODE_TICK,
      MODE_CLEAR
   } mode_type;

   typedef enum logic [3:0] {
      S_RST,
      S_RST_WAIT,
      S_IDLE,
      S_DISPATCH,
      S_SEARCH,
      S_DECIDE,
      S_WRITE,
      S_SWEEP,
      S_FRAG,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic     load;
      logic     start;
      mode_type mode;
      logic     emit;
   } cmd_type;

   typedef struct packed {
      logic   done;
      op_type op;
      logic   alloc_ok;
      logic   found;
      logic   out_free;
   } sts_type;

endpackage

@@ rtl/cfa_ctrl.sv @@
// sequencer that orders the memory passes of one operation
module cfa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cfa_pkg::sts_type  sts,
   output cfa_pkg::cmd_type  cmd
);

   cfa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfa_pkg::S_RST;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd.load  = 1'b0;
      cmd.start = 1'b0;
      cmd.mode  = cfa_pkg::MODE_FRAG;
      cmd.emit  = 1'b0;
      case (state_ff)
         cfa_pkg::S_RST: begin
            cmd.start = 1'b1;
            cmd.mode  = cfa_pkg::MODE_CLEAR;
            state_in  = cfa_pkg::S_RST_WAIT;
         end
         cfa_pkg::S_RST_WAIT: begin
            if (sts.done) state_in = cfa_pkg::S_IDLE;
         end
         cfa_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = cfa_pkg::S_DISPATCH;
            end
         end
         cfa_pkg::S_DISPATCH: begin
            cmd.start = 1'b1;
            case (sts.op)
               cfa_pkg::OP_ALLOC: begin
                  if (sts.alloc_ok) begin
                     cmd.mode = cfa_pkg::MODE_SEARCH;
                     state_in = cfa_pkg::S_SEARCH;
                  end else begin
                     cmd.mode = cfa_pkg::MODE_FRAG;
                     state_in = cfa_pkg::S_FRAG;
                  end
               end
               cfa_pkg::OP_TICK: begin
                  cmd.mode = cfa_pkg::MODE_TICK;
                  state_in = cfa_pkg::S_SWEEP;
               end
               cfa_pkg::OP_CLEAR: begin
                  cmd.mode = cfa_pkg::MODE_CLEAR;
                  state_in = cfa_pkg::S_SWEEP;
               end
               default: begin
                  cmd.mode = cfa_pkg::MODE_FRAG;
                  state_in = cfa_pkg::S_FRAG;
               end
            endcase
         end
         cfa_pkg::S_SEARCH: begin
            if (sts.done) state_in = cfa_pkg::S_DECIDE;
         end
         cfa_pkg::S_DECIDE: begin
            cmd.start = 1'b1;
            if (sts.found) begin
               cmd.mode = cfa_pkg::MODE_WRITE;
               state_in = cfa_pkg::S_WRITE;
            end else begin
               cmd.mode = cfa_pkg::MODE_FRAG;
               state_in = cfa_pkg::S_FRAG;
            end
         end
         cfa_pkg::S_WRITE, cfa_pkg::S_SWEEP: begin
            if (sts.done) begin
               cmd.start = 1'b1;
               cmd.mode  = cfa_pkg::MODE_FRAG;
               state_in  = cfa_pkg::S_FRAG;
            end
         end
         cfa_pkg::S_FRAG: begin
            if (sts.done) state_in = cfa_pkg::S_EMIT;
         end
         cfa_pkg::S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = cfa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cfa_pkg::S_RST;
         end
      endcase
   end

endmodule

@@ rtl/cfa_dp.sv @@
// unit store, address sweep, run tracker, search results and response register
module cfa_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [cfa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cfa_pkg::CSR_W-1:0]    csr_wdata,
   input  logic [1:0]                   req_op,
   input  logic [10:0]                  req_alloc_size,
   input  logic [7:0]                   req_duration,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_success,
   output logic [9:0]                   rsp_runs_probed,
   output logic [9:0]                   rsp_start_unit,
   output logic [9:0]                   rsp_fragment_count,
   input  cfa_pkg::cmd_type             cmd,
   output cfa_pkg::sts_type             sts
);

   localparam int AW = cfa_pkg::ADDR_W;
   localparam int CW = cfa_pkg::CNT_W;
   localparam int LW = cfa_pkg::LIFE_W;
   localparam logic [AW-1:0] LAST_UNIT = AW'(cfa_pkg::MAX_UNITS - 1);

   logic [LW-1:0] mem [cfa_pkg::MAX_UNITS];

   // configuration
   logic [CW-1:0]         units_ff, units_in;
   cfa_pkg::strat_type    strat_ff, strat_in;
   logic [CW-1:0]         thr_ff, thr_in;
   // current item
   cfa_pkg::op_type       op_ff, op_in;
   logic [CW-1:0]         size_ff, size_in;
   logic [LW-1:0]         dur_ff, dur_in;
   logic                  ok_ff, ok_in;
   // address sweep
   cfa_pkg::mode_type     mode_ff, mode_in;
   logic                  busy_ff, busy_in;
   logic [AW-1:0]         cnt_ff, cnt_in;
   logic [AW-1:0]         end_ff, end_in;
   logic                  p1_vld_ff, p1_vld_in;
   logic [AW-1:0]         p1_idx_ff, p1_idx_in;
   logic                  p1_last_ff, p1_last_in;
   logic [LW-1:0]         mem_q_ff;
   // run tracker
   logic                  in_run_ff, in_run_in;
   logic [AW-1:0]         rs_ff, rs_in;
   logic [CW-1:0]         rl_ff, rl_in;
   // search bookkeeping
   logic [CW-1:0]         tot_ff, tot_in, hic_ff, hic_in, loc_ff, loc_in;
   logic                  hi_found_ff, hi_found_in, lo_found_ff, lo_found_in;
   logic                  ff_found_ff, ff_found_in, bf_found_ff, bf_found_in;
   logic [AW-1:0]         hi_at_ff, hi_at_in, lo_at_ff, lo_at_in;
   logic [AW-1:0]         ff_at_ff, ff_at_in, bf_at_ff, bf_at_in;
   logic [CW-1:0]         hi_pr_ff, hi_pr_in, lo_pr_ff, lo_pr_in, ff_pr_ff, ff_pr_in;
   logic [CW-1:0]         bf_len_ff, bf_len_in;
   logic [CW-1:0]         frag_ff, frag_in;
   logic [AW-1:0]         nfp_ff, nfp_in;
   // response
   logic                  rv_ff, rv_in;
   logic                  rs_succ_ff, rs_succ_in;
   logic [9:0]            rs_pr_ff, rs_pr_in, rs_at_ff, rs_at_in, rs_frag_ff, rs_frag_in;

   logic [CW-1:0]  n_units;
   logic [AW-1:0]  n_last;
   logic [AW-1:0]  p_eff;
   logic           unit_free;
   logic [CW-1:0]  len_new;
   logic [AW-1:0]  start_new;
   logic           closing;
   logic [CW-1:0]  close_len;
   logic [AW-1:0]  close_start;
   logic           close_hi;
   logic           fit;
   logic           res_found;
   logic [AW-1:0]  res_at;
   logic [CW-1:0]  res_pr;
   logic [CW-1:0]  wr_end;
   logic           mem_we;
   logic [LW-1:0]  mem_wd;
   logic           track;
   logic           succ;

   always_comb begin
      if (units_ff == '0) begin
         n_units = CW'(1);
      end else if (units_ff > CW'(cfa_pkg::MAX_UNITS)) begin
         n_units = CW'(cfa_pkg::MAX_UNITS);
      end else begin
         n_units = units_ff;
      end
   end
   assign n_last = AW'(n_units - CW'(1));
   // a stale pointer restarts at unit zero
   assign p_eff  = ({1'b0, nfp_ff} >= n_units) ? '0 : nfp_ff;

   // run boundaries seen at the read data stage
   assign unit_free   = (mem_q_ff == '0);
   assign len_new     = in_run_ff ? rl_ff + CW'(1) : CW'(1);
   assign start_new   = in_run_ff ? rs_ff : p1_idx_ff;
   assign closing     = unit_free ? p1_last_ff : in_run_ff;
   assign close_len   = unit_free ? len_new : rl_ff;
   assign close_start = unit_free ? start_new : rs_ff;
   // run reaches the pointer or lies beyond it
   assign close_hi    = unit_free ? (p1_idx_ff >= p_eff) : (p1_idx_ff > p_eff);
   assign fit         = (close_len >= size_ff);
   assign track       = p1_vld_ff &&
                        (mode_ff == cfa_pkg::MODE_SEARCH || mode_ff == cfa_pkg::MODE_FRAG);

   always_comb begin
      res_found = 1'b0;
      res_at    = '0;
      res_pr    = tot_ff;
      case (strat_ff)
         cfa_pkg::STRAT_BEST: begin
            res_found = bf_found_ff;
            res_at    = bf_at_ff;
         end
         cfa_pkg::STRAT_FIRST: begin
            res_found = ff_found_ff;
            res_at    = ff_at_ff;
            if (ff_found_ff) res_pr = ff_pr_ff;
         end
         cfa_pkg::STRAT_NEXT: begin
            if (hi_found_ff) begin
               res_found = 1'b1;
               res_at    = hi_at_ff;
               res_pr    = hi_pr_ff;
            end else if (lo_found_ff) begin
               res_found = 1'b1;
               res_at    = lo_at_ff;
               res_pr    = hic_ff + lo_pr_ff;
            end
         end
         default: begin
            res_found = 1'b0;
         end
      endcase
   end

   assign wr_end = {1'b0, res_at} + size_ff - CW'(1);

   always_comb begin
      mem_we = 1'b0;
      mem_wd = '0;
      if (p1_vld_ff) begin
         case (mode_ff)
            cfa_pkg::MODE_TICK: begin
               mem_we = 1'b1;
               mem_wd = unit_free ? mem_q_ff : mem_q_ff - LW'(1);
            end
            cfa_pkg::MODE_CLEAR: begin
               mem_we = 1'b1;
            end
            cfa_pkg::MODE_WRITE: begin
               mem_we = 1'b1;
               mem_wd = dur_ff;
            end
            default: begin
               mem_we = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      case (op_ff)
         cfa_pkg::OP_ALLOC:                  succ = ok_ff && res_found;
         cfa_pkg::OP_TICK, cfa_pkg::OP_CLEAR: succ = 1'b1;
         default:                            succ = 1'b0;
      endcase
   end

   always_comb begin
      units_in    = units_ff;
      strat_in    = strat_ff;
      thr_in      = thr_ff;
      op_in       = op_ff;
      size_in     = size_ff;
      dur_in      = dur_ff;
      ok_in       = ok_ff;
      mode_in     = mode_ff;
      busy_in     = busy_ff;
      cnt_in      = cnt_ff;
      end_in      = end_ff;
      p1_vld_in   = 1'b0;
      p1_idx_in   = p1_idx_ff;
      p1_last_in  = p1_last_ff;
      in_run_in   = in_run_ff;
      rs_in       = rs_ff;
      rl_in       = rl_ff;
      tot_in      = tot_ff;
      hic_in      = hic_ff;
      loc_in      = loc_ff;
      hi_found_in = hi_found_ff;
      lo_found_in = lo_found_ff;
      ff_found_in = ff_found_ff;
      bf_found_in = bf_found_ff;
      hi_at_in    = hi_at_ff;
      lo_at_in    = lo_at_ff;
      ff_at_in    = ff_at_ff;
      bf_at_in    = bf_at_ff;
      hi_pr_in    = hi_pr_ff;
      lo_pr_in    = lo_pr_ff;
      ff_pr_in    = ff_pr_ff;
      bf_len_in   = bf_len_ff;
      frag_in     = frag_ff;
      nfp_in      = nfp_ff;
      rv_in       = rv_ff;
      rs_succ_in  = rs_succ_ff;
      rs_pr_in    = rs_pr_ff;
      rs_at_in    = rs_at_ff;
      rs_frag_in  = rs_frag_ff;

      if (csr_wr_en) begin
         case (csr_index)
            cfa_pkg::CSR_UNITS:    units_in = csr_wdata;
            cfa_pkg::CSR_STRATEGY: strat_in = cfa_pkg::strat_type'(csr_wdata[1:0]);
            cfa_pkg::CSR_THRESH:   thr_in   = csr_wdata;
            default:               units_in = units_ff;
         endcase
      end

      if (cmd.load) begin
         op_in       = cfa_pkg::op_type'(req_op);
         size_in     = req_alloc_size;
         dur_in      = req_duration;
         ok_in       = (cfa_pkg::op_type'(req_op) == cfa_pkg::OP_ALLOC) &&
                       (req_alloc_size != '0) && (req_alloc_size <= n_units) &&
                       (strat_ff != cfa_pkg::STRAT_NONE);
         tot_in      = '0;
         hic_in      = '0;
         loc_in      = '0;
         hi_found_in = 1'b0;
         lo_found_in = 1'b0;
         ff_found_in = 1'b0;
         bf_found_in = 1'b0;
      end

      // issue one read address per cycle
      if (busy_ff) begin
         p1_vld_in  = 1'b1;
         p1_idx_in  = cnt_ff;
         p1_last_in = (cnt_ff == end_ff);
         if (cnt_ff == end_ff) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + AW'(1);
         end
      end

      if (track) begin
         in_run_in = unit_free && !p1_last_ff;
         rs_in     = start_new;
         rl_in     = len_new;
         if (closing) begin
            if (mode_ff == cfa_pkg::MODE_FRAG) begin
               if (close_len <= thr_ff) frag_in = frag_ff + CW'(1);
            end else begin
               tot_in = tot_ff + CW'(1);
               if (fit && !ff_found_ff) begin
                  ff_found_in = 1'b1;
                  ff_at_in    = close_start;
                  ff_pr_in    = tot_ff + CW'(1);
               end
               if (fit && (!bf_found_ff || close_len < bf_len_ff)) begin
                  bf_found_in = 1'b1;
                  bf_at_in    = close_start;
                  bf_len_in   = close_len;
               end
               if (close_hi) begin
                  hic_in = hic_ff + CW'(1);
                  if (fit && !hi_found_ff) begin
                     hi_found_in = 1'b1;
                     hi_at_in    = close_start;
                     hi_pr_in    = hic_ff + CW'(1);
                  end
               end else begin
                  loc_in = loc_ff + CW'(1);
                  if (fit && !lo_found_ff) begin
                     lo_found_in = 1'b1;
                     lo_at_in    = close_start;
                     lo_pr_in    = loc_ff + CW'(1);
                  end
               end
            end
         end
      end

      if (cmd.start) begin
         mode_in   = cmd.mode;
         busy_in   = 1'b1;
         in_run_in = 1'b0;
         cnt_in    = '0;
         case (cmd.mode)
            cfa_pkg::MODE_SEARCH: end_in = n_last;
            cfa_pkg::MODE_FRAG: begin
               end_in  = n_last;
               frag_in = '0;
            end
            cfa_pkg::MODE_WRITE: begin
               cnt_in = res_at;
               end_in = wr_end[AW-1:0];
            end
            default: end_in = LAST_UNIT;
         endcase
      end

      if (rv_ff && rsp_ready) rv_in = 1'b0;

      if (cmd.emit) begin
         rv_in      = 1'b1;
         rs_succ_in = succ;
         rs_pr_in   = ok_ff ? res_pr[9:0] : '0;
         rs_at_in   = (succ && op_ff == cfa_pkg::OP_ALLOC) ? res_at : '0;
         rs_frag_in = frag_ff[9:0];
         if (succ && op_ff == cfa_pkg::OP_ALLOC && strat_ff == cfa_pkg::STRAT_NEXT) begin
            nfp_in = res_at;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[p1_idx_ff] <= mem_wd;
      if (busy_ff) mem_q_ff <= mem[cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         units_ff  <= CW'(cfa_pkg::MAX_UNITS);
         strat_ff  <= cfa_pkg::STRAT_BEST;
         thr_ff    <= '0;
         busy_ff   <= 1'b0;
         p1_vld_ff <= 1'b0;
         nfp_ff    <= '0;
         rv_ff     <= 1'b0;
         mode_ff   <= cfa_pkg::MODE_CLEAR;
      end else begin
         units_ff  <= units_in;
         strat_ff  <= strat_in;
         thr_ff    <= thr_in;
         busy_ff   <= busy_in;
         p1_vld_ff <= p1_vld_in;
         nfp_ff    <= nfp_in;
         rv_ff     <= rv_in;
         mode_ff   <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      size_ff     <= size_in;
      dur_ff      <= dur_in;
      ok_ff       <= ok_in;
      cnt_ff      <= cnt_in;
      end_ff      <= end_in;
      p1_idx_ff   <= p1_idx_in;
      p1_last_ff  <= p1_last_in;
      in_run_ff   <= in_run_in;
      rs_ff       <= rs_in;
      rl_ff       <= rl_in;
      tot_ff      <= tot_in;
      hic_ff      <= hic_in;
      loc_ff      <= loc_in;
      hi_found_ff <= hi_found_in;
      lo_found_ff <= lo_found_in;
      ff_found_ff <= ff_found_in;
      bf_found_ff <= bf_found_in;
      hi_at_ff    <= hi_at_in;
      lo_at_ff    <= lo_at_in;
      ff_at_ff    <= ff_at_in;
      bf_at_ff    <= bf_at_in;
      hi_pr_ff    <= hi_pr_in;
      lo_pr_ff    <= lo_pr_in;
      ff_pr_ff    <= ff_pr_in;
      bf_len_ff   <= bf_len_in;
      frag_ff     <= frag_in;
      rs_succ_ff  <= rs_succ_in;
      rs_pr_ff    <= rs_pr_in;
      rs_at_ff    <= rs_at_in;
      rs_frag_ff  <= rs_frag_in;
   end

   assign sts.done     = p1_vld_ff && p1_last_ff;
   assign sts.op       = op_ff;
   assign sts.alloc_ok = ok_ff;
   assign sts.found    = res_found;
   assign sts.out_free = !rv_ff || rsp_ready;

   assign rsp_valid          = rv_ff;
   assign rsp_success        = rs_succ_ff;
   assign rsp_runs_probed    = rs_pr_ff;
   assign rsp_start_unit     = rs_at_ff;
   assign rsp_fragment_count = rs_frag_ff;

endmodule

@@ rtl/contiguous_fit_allocator.sv @@
// top level of the contiguous fit allocator
//
// req channel (valid/ready) carries one operation per beat: allocate,
// tick or clear. rsp channel (valid/ready) returns one beat per request
// with success, runs probed, start unit and fragment count.
// csr port: csr_wr_en writes csr_wdata into register csr_index at once
// (0 units in use, 1 placement strategy, 2 fragment threshold).
// the unit store is a 1024 x 8 memory with one registered read port;
// every pass walks it one unit per cycle.
// allocate: a search pass over n units, a write pass over size units on
// success, then a fragment pass over n units.
// tick and clear: a sweep of all 1024 units plus the fragment pass.
// other ops and rejected allocations: fragment pass only.
// one operation is in flight at a time; req_ready is high only when idle.
// a finished beat waits in the response register while the next request
// is taken; a stalled receiver holds back only the end of the next op.
// after reset the store is cleared by a pass over all 1024 units before the first
// request is accepted; csr writes are taken during it.
module contiguous_fit_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_op,
   input  logic [10:0]                   req_alloc_size,
   input  logic [7:0]                    req_duration,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_success,
   output logic [9:0]                    rsp_runs_probed,
   output logic [9:0]                    rsp_start_unit,
   output logic [9:0]                    rsp_fragment_count,
   input  logic                          csr_wr_en,
   input  logic [cfa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cfa_pkg::CSR_W-1:0]     csr_wdata
);

   cfa_pkg::cmd_type cmd;
   cfa_pkg::sts_type sts;

   cfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cfa_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_op             (req_op),
      .req_alloc_size     (req_alloc_size),
      .req_duration       (req_duration),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_success        (rsp_success),
      .rsp_runs_probed    (rsp_runs_probed),
      .rsp_start_unit     (rsp_start_unit),
      .rsp_fragment_count (rsp_fragment_count),
      .cmd                (cmd),
      .sts                (sts)
   );

endmodule

@@ bench/contiguous_fit_allocator_tb.sv @@
// testbench of the contiguous fit allocator: directed table plus random ops checked against a predictor
`timescale 1ns / 100ps

module contiguous_fit_allocator_tb;

   localparam int STALL_LIMIT = 40000;

   typedef struct {
      cfa_pkg::op_type op;
      logic [10:0]     size;
      logic [7:0]      dur;
      logic            typed;
      logic            succ;
      logic [9:0]      probes;
      logic [9:0]      start;
      logic [9:0]      frags;
   } alloc_row;

   typedef struct packed {
      logic       succ;
      logic [9:0] probes;
      logic [9:0] start;
      logic [9:0] frags;
   } alloc_result;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_op = cfa_pkg::OP_TICK;
   logic [10:0] req_alloc_size = 11'd1;
   logic [7:0] req_duration = 8'd1;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_success;
   logic [9:0] rsp_runs_probed, rsp_start_unit, rsp_fragment_count;
   logic csr_wr_en = 1'b0;
   logic [cfa_pkg::CSR_IDX_W-1:0] csr_index = cfa_pkg::CSR_UNITS;
   logic [cfa_pkg::CSR_W-1:0] csr_wdata = '0;

   // predictor state
   logic [7:0]          life_store [cfa_pkg::MAX_UNITS];
   logic [9:0]          nf_ptr;
   logic [10:0]         cfg_units;
   cfa_pkg::strat_type  cfg_strat;
   logic [10:0]         cfg_thresh;

   alloc_result pending_results[$];
   int errors = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;
   bit hold_off = 1'b0;
   bit stim_done = 1'b0;

   always #6 clock = ~clock;

   contiguous_fit_allocator uut (.*);

   function automatic int managed_units();
      if (cfg_units == 0) return 1;
      if (cfg_units > cfa_pkg::MAX_UNITS) return cfa_pkg::MAX_UNITS;
      return int'(cfg_units);
   endfunction

   function automatic int run_end(int i, int n);
      int j;
      j = i;
      while (j < n && life_store[j] == 0) j++;
      return j;
   endfunction

   function automatic bit first_run(int lo, int hi, int n, int sz,
                                    inout int probes, inout int at);
      int i, j;
      i = lo;
      while (i < hi) begin
         if (life_store[i] == 0) begin
            probes++;
            j = run_end(i, n);
            if (j - i >= sz) begin
               at = i;
               return 1'b1;
            end
            i = j;
         end else i++;
      end
      return 1'b0;
   endfunction

   function automatic alloc_result predict_op(cfa_pkg::op_type op, int sz, logic [7:0] dur);
      alloc_result r;
      int n, probes, at, p, i, j, best_len, frags;
      bit found;
      n = managed_units();
      probes = 0; at = 0; found = 0; best_len = 0;
      r.succ = 1'b0;
      case (op)
         cfa_pkg::OP_ALLOC: begin
            if (sz != 0 && sz <= n) begin
               if (cfg_strat == cfa_pkg::STRAT_BEST) begin
                  i = 0;
                  while (i < n) begin
                     if (life_store[i] == 0) begin
                        probes++;
                        j = run_end(i, n);
                        if (j - i >= sz && (!found || j - i < best_len)) begin
                           found = 1; best_len = j - i; at = i;
                        end
                        i = j;
                     end else i++;
                  end
               end else if (cfg_strat == cfa_pkg::STRAT_FIRST) begin
                  found = first_run(0, n, n, sz, probes, at);
               end else if (cfg_strat == cfa_pkg::STRAT_NEXT) begin
                  p = int'(nf_ptr);
                  if (p >= n) p = 0;
                  if (life_store[p] == 0)
                     while (p > 0 && life_store[p-1] == 0) p--;
                  found = first_run(p, n, n, sz, probes, at);
                  if (!found) found = first_run(0, p, n, sz, probes, at);
                  if (found) nf_ptr = at[9:0];
               end
            end
            if (found) begin
               for (i = at; i < at + sz; i++) life_store[i] = dur;
               r.succ = 1'b1;
            end else at = 0;
         end
         cfa_pkg::OP_TICK: begin
            foreach (life_store[k]) if (life_store[k] != 0) life_store[k]--;
            r.succ = 1'b1;
         end
         cfa_pkg::OP_CLEAR: begin
            foreach (life_store[k]) life_store[k] = '0;
            r.succ = 1'b1;
         end
         default: ;
      endcase
      frags = 0; i = 0;
      while (i < n) begin
         if (life_store[i] == 0) begin
            j = run_end(i, n);
            if (j - i <= cfg_thresh) frags++;
            i = j;
         end else i++;
      end
      r.probes = probes[9:0];
      r.start = at[9:0];
      r.frags = frags[9:0];
      return r;
   endfunction

   // returns at the falling edge after the accepting edge with valid still high
   task automatic send_op(cfa_pkg::op_type op, logic [10:0] sz, logic [7:0] dur,
                          bit typed = 0, alloc_result want = '{0, 0, 0, 0});
      alloc_result got;
      while (!quiet && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_alloc_size <= sz;
      req_duration <= dur;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      got = predict_op(op, int'(sz), dur);
      if (typed && got !== want) begin
         $error("table row disagrees with predictor: op %0d", op);
         errors++;
      end
      pending_results.push_back(got);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [cfa_pkg::CSR_IDX_W-1:0] idx,
                            logic [cfa_pkg::CSR_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         cfa_pkg::CSR_UNITS:    cfg_units = val;
         cfa_pkg::CSR_STRATEGY: cfg_strat = cfa_pkg::strat_type'(val[1:0]);
         cfa_pkg::CSR_THRESH:   cfg_thresh = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      while (pending_results.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      // let the block settle before the next configuration write
      repeat (2200) @(negedge clock);
   endtask

   // receiver
   always @(negedge clock) begin
      if (hold_off) rsp_ready <= 1'b0;
      else rsp_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 8);
   end

   always @(posedge clock) begin
      alloc_result want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("response beat with nothing expected");
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_success !== want.succ) begin
               $error("success: expected %0d actual %0d", want.succ, rsp_success);
               errors++;
            end
            if (rsp_runs_probed !== want.probes) begin
               $error("runs_probed: expected %0d actual %0d", want.probes,
                      rsp_runs_probed);
               errors++;
            end
            if (rsp_start_unit !== want.start) begin
               $error("start_unit: expected %0d actual %0d", want.start,
                      rsp_start_unit);
               errors++;
            end
            if (rsp_fragment_count !== want.frags) begin
               $error("fragment_count: expected %0d actual %0d", want.frags,
                      rsp_fragment_count);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || stim_done)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   alloc_row dir_rows[$];

   task automatic add_row(cfa_pkg::op_type op, int sz, int dur, bit typed = 0, int s = 0,
                          int p = 0, int st = 0, int f = 0);
      alloc_row row;
      row.op = op; row.size = sz[10:0]; row.dur = dur[7:0]; row.typed = typed;
      row.succ = s[0]; row.probes = p[9:0]; row.start = st[9:0]; row.frags = f[9:0];
      dir_rows.push_back(row);
   endtask

   task automatic random_phase(int count);
      int sel, sz;
      cfa_pkg::op_type op;
      for (int k = 0; k < count; k++) begin
         sel = $urandom_range(99);
         if (sel < 70) op = cfa_pkg::OP_ALLOC;
         else if (sel < 88) op = cfa_pkg::OP_TICK;
         else if (sel < 94) op = cfa_pkg::OP_CLEAR;
         else op = cfa_pkg::OP_NONE;
         sel = $urandom_range(99);
         if (sel < 75) sz = $urandom_range(1, 24);
         else if (sel < 90) sz = $urandom_range(0, 200);
         else sz = $urandom_range(0, 2047);
         send_op(op, sz[10:0], (sel < 5) ? 8'd0 : 8'($urandom_range(1, 255)));
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      alloc_result want;
      foreach (life_store[k]) life_store[k] = '0;
      nf_ptr = '0;
      cfg_units = 11'd1024;
      cfg_strat = cfa_pkg::STRAT_BEST;
      cfg_thresh = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty store, best fit, 1024 units, threshold 0
      add_row(cfa_pkg::OP_ALLOC, 1024, 255, 1, 1, 1, 0, 0);
      add_row(cfa_pkg::OP_ALLOC, 1, 1, 1, 0, 0, 0, 0);
      add_row(cfa_pkg::OP_CLEAR, 0, 0, 1, 1, 0, 0, 0);
      add_row(cfa_pkg::OP_ALLOC, 0, 5, 1, 0, 0, 0, 0);
      add_row(cfa_pkg::OP_ALLOC, 1025, 5, 1, 0, 0, 0, 0);
      add_row(cfa_pkg::OP_ALLOC, 2047, 5, 1, 0, 0, 0, 0);
      add_row(cfa_pkg::OP_NONE, 3, 3, 1, 0, 0, 0, 0);
      add_row(cfa_pkg::OP_ALLOC, 10, 2, 1, 1, 1, 0, 0);
      add_row(cfa_pkg::OP_ALLOC, 5, 1, 1, 1, 1, 10, 0);
      add_row(cfa_pkg::OP_ALLOC, 4, 0, 1, 1, 1, 15, 0);
      add_row(cfa_pkg::OP_TICK, 0, 0);
      add_row(cfa_pkg::OP_ALLOC, 7, 9);
      add_row(cfa_pkg::OP_TICK, 1, 255);
      add_row(cfa_pkg::OP_ALLOC, 1, 128);
      foreach (dir_rows[r]) begin
         want = '{dir_rows[r].succ, dir_rows[r].probes, dir_rows[r].start,
                  dir_rows[r].frags};
         send_op(dir_rows[r].op, dir_rows[r].size, dir_rows[r].dur,
                 dir_rows[r].typed, want);
      end
      req_valid <= 1'b0;
      drain();

      // first fit, small store, big threshold; quiet stretch
      write_csr(cfa_pkg::CSR_UNITS, 11'd64);
      write_csr(cfa_pkg::CSR_STRATEGY, cfa_pkg::STRAT_FIRST);
      write_csr(cfa_pkg::CSR_THRESH, 11'd1024);
      quiet = 1'b1;
      random_phase(40);
      drain();
      quiet = 1'b0;

      // next fit with a zero size register
      write_csr(cfa_pkg::CSR_STRATEGY, cfa_pkg::STRAT_NEXT);
      write_csr(cfa_pkg::CSR_UNITS, 11'd0);
      write_csr(cfa_pkg::CSR_THRESH, 11'd2047);
      random_phase(10);
      drain();
      write_csr(cfa_pkg::CSR_UNITS, 11'd48);
      write_csr(cfa_pkg::CSR_THRESH, 11'd3);
      random_phase(80);
      drain();

      // receiver hold-off while the sender keeps offering
      fork
         begin
            hold_off = 1'b1;
            repeat (3000) @(negedge clock);
            hold_off = 1'b0;
         end
         random_phase(6);
      join
      drain();

      // unused strategy, then best fit with oversized unit register
      write_csr(cfa_pkg::CSR_STRATEGY, cfa_pkg::STRAT_NONE);
      random_phase(10);
      drain();
      write_csr(cfa_pkg::CSR_STRATEGY, cfa_pkg::STRAT_BEST);
      write_csr(cfa_pkg::CSR_UNITS, 11'd2047);
      write_csr(cfa_pkg::CSR_THRESH, 11'd0);
      random_phase(15);
      drain();
      write_csr(cfa_pkg::CSR_UNITS, 11'd32);
      write_csr(cfa_pkg::CSR_THRESH, 11'd2);
      random_phase(70);
      drain();
      write_csr(cfa_pkg::CSR_UNITS, 11'd1);
      write_csr(cfa_pkg::CSR_STRATEGY, cfa_pkg::STRAT_FIRST);
      random_phase(20);
      drain();
      write_csr(cfa_pkg::CSR_UNITS, 11'd96);
      write_csr(cfa_pkg::CSR_STRATEGY, cfa_pkg::STRAT_NEXT);
      write_csr(cfa_pkg::CSR_THRESH, 11'd5);
      random_phase(14);
      stim_done = 1'b1;
      drain();

      if (errors == 0 && pending_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
